// File: hdl/vnpd_pkg.sv
// Shared types and constants for the voxel nearest point distance block.
`default_nettype none

package vnpd_pkg;

    // Field widths
    localparam int COORD_BITS = 20;
    localparam int SLOT_W     = 10;
    localparam int COUNT_W    = 11;
    localparam int DIST_SQ_W  = 36;
    localparam int DIST_W     = 18;
    localparam int CFG_IDX_W  = 1;

    // Arithmetic widths of the distance datapath
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int DSQ_W  = SQ_W + 2;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATOM_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BULK_DIST_SQ = 1'b1;

    // Reset values and the distance ceiling (1000000 square angstrom)
    localparam logic [COUNT_W-1:0]   ATOM_COUNT_RST = '0;
    localparam logic [DIST_SQ_W-1:0] BULK_DIST_RST  = 36'd6553600;
    localparam logic [DIST_SQ_W-1:0] CEILING_SQ     = 36'd65536000000;

    // Leading power of four for the root iteration
    localparam logic [DIST_SQ_W-1:0] SQRT_ONE_INIT = 36'h400000000;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic                command;
        logic [SLOT_W-1:0]   atom_index;
        t_coord              point_x;
        t_coord              point_y;
        t_coord              point_z;
    } t_in;

    typedef struct packed {
        logic [DIST_SQ_W-1:0] min_dist_sq;
        logic [DIST_W-1:0]    min_dist;
        logic                 is_bulk;
    } t_out;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    // Scan result handed from the scan engine to the root unit
    typedef struct packed {
        logic [DIST_SQ_W-1:0] dist_sq;
        logic                 is_bulk;
    } t_sqrt_req;

endpackage

`default_nettype wire

// File: hdl/voxel_nearest_point_distance.sv
// Top level of the voxel nearest point distance block.
//
//  Channel | Direction | Signals                          | Moves
//  --------+-----------+----------------------------------+-------------------------
//  in      | input     | i_in_valid o_in_ready i_in_data  | load or query command
//  out     | output    | o_out_valid i_out_ready o_out_data | one result per query
//  cfg     | input     | i_cfg_valid o_cfg_ready i_cfg_index i_cfg_data | register write
//
// A load is written to the point store by the scan engine and starts no scan. A query
// scans min(atom_count, MAX_ATOMS) slots there: one point store read per cycle feeds
// a pipelined distance datapath.
// The floor root then runs in its own unit, overlapped with the next command.
// Reset is synchronous and clears control state; the point store is not cleared.
// A two entry queue between the front end and the scan engine absorbs input while a scan
// runs; a result waiting on the out channel stalls the root unit, and through it the scan engine.
`default_nettype none

module voxel_nearest_point_distance #(
    parameter int MAX_ATOMS = 1024
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  vnpd_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output vnpd_pkg::t_out                  o_out_data,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [vnpd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [vnpd_pkg::DIST_SQ_W-1:0]   i_cfg_data
);
    import vnpd_pkg::*;

    logic [COUNT_W-1:0]    r_atom_count;
    logic [DIST_SQ_W-1:0]  r_bulk_dist_sq;
    logic                  w_q_valid;
    logic                  w_q_pop;
    t_in                   w_q_data;
    logic                  w_req_valid;
    logic                  w_req_ready;
    t_sqrt_req             w_req;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atom_count   <= ATOM_COUNT_RST;
            r_bulk_dist_sq <= BULK_DIST_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ATOM_COUNT:   r_atom_count   <= i_cfg_data[COUNT_W-1:0];
                CFG_BULK_DIST_SQ: r_bulk_dist_sq <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    vnpd_front #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (w_q_valid),
        .i_q_pop    (w_q_pop),
        .o_q_data   (w_q_data)
    );

    vnpd_scan #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .o_q_pop        (w_q_pop),
        .i_q_data       (w_q_data),
        .i_atom_count   (r_atom_count),
        .i_bulk_dist_sq (r_bulk_dist_sq),
        .o_req_valid    (w_req_valid),
        .i_req_ready    (w_req_ready),
        .o_req          (w_req)
    );

    vnpd_sqrt u_sqrt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .o_req_ready (w_req_ready),
        .i_req       (w_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Root is the floor square root of the reported minimum
    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((64'(o_out_data.min_dist) * 64'(o_out_data.min_dist))
                <= 64'(o_out_data.min_dist_sq)) &&
            ((64'(o_out_data.min_dist) + 64'd1) * (64'(o_out_data.min_dist) + 64'd1)
                > 64'(o_out_data.min_dist_sq)))
        else $error("root does not match reported minimum");

    // A cleared bulk flag means the minimum lies within the threshold
    a_bulk_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.is_bulk) |->
            (o_out_data.min_dist_sq <= r_bulk_dist_sq))
        else $error("bulk flag clear with minimum above threshold");

    // Minimum never exceeds the ceiling
    a_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.min_dist_sq <= CEILING_SQ))
        else $error("minimum above ceiling");

    // A scan request stays up until the root unit takes it
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req_valid && !w_req_ready) |=> (w_req_valid && $stable(w_req)))
        else $error("scan result dropped before the root unit took it");

endmodule

`default_nettype wire

// File: hdl/vnpd_front.sv
// Front end: accepts commands, drops loads to absent slots, queues the rest.
`default_nettype none

module vnpd_front #(
    parameter int MAX_ATOMS = 1024
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  vnpd_pkg::t_in   i_in_data,
    output logic            o_q_valid,
    input  wire             i_q_pop,
    output vnpd_pkg::t_in   o_q_data
);
    import vnpd_pkg::*;

    localparam int QDEPTH = 2;
    localparam int PTR_W  = 1;

    t_in               r_q [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W:0]    r_count;
    logic              w_accept;
    logic              w_in_range;
    logic              w_push;
    logic              w_pop;

    // Classify the incoming transfer
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = 32'(i_in_data.atom_index) < 32'(MAX_ATOMS);
    assign w_push     = w_accept && ((i_in_data.command == CMD_QUERY) || w_in_range);
    assign w_pop      = i_q_pop && o_q_valid;

    assign o_in_ready = r_count != (PTR_W + 1)'(QDEPTH);
    assign o_q_valid  = r_count != '0;
    assign o_q_data   = r_q[r_rd_ptr];

    // Hold queued entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= i_in_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/vnpd_scan.sv
// Back end: point store, pipelined distance scan and minimum search.
`default_nettype none

module vnpd_scan #(
    parameter int MAX_ATOMS = 1024
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_valid,
    output logic                         o_q_pop,
    input  vnpd_pkg::t_in                i_q_data,
    input  wire [vnpd_pkg::COUNT_W-1:0]  i_atom_count,
    input  wire [vnpd_pkg::DIST_SQ_W-1:0] i_bulk_dist_sq,
    output logic                         o_req_valid,
    input  wire                          i_req_ready,
    output vnpd_pkg::t_sqrt_req          o_req
);
    import vnpd_pkg::*;

    localparam int AW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNTW = ($clog2(MAX_ATOMS + 1) > COUNT_W) ?
                          $clog2(MAX_ATOMS + 1) : COUNT_W;
    localparam logic [CNTW-1:0] N_MAX = CNTW'(MAX_ATOMS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HAND = 2'd2;

    t_point                r_mem [MAX_ATOMS];
    t_point                r_mem_q;
    logic [1:0]            r_state;
    logic [1:0]            n_state;
    t_coord                r_qx;
    t_coord                r_qy;
    t_coord                r_qz;
    logic [CNTW-1:0]       r_n;
    logic [CNTW-1:0]       r_idx;
    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    logic [SQ_W-1:0]       r_sqx;
    logic [SQ_W-1:0]       r_sqy;
    logic [SQ_W-1:0]       r_sqz;
    logic [DSQ_W-1:0]      r_dsq;
    logic [DIST_SQ_W-1:0]  r_best;
    logic                  r_bulk;

    logic                  w_start;
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic                  w_scan_done;
    logic [AW+SLOT_W-1:0]  w_slot_ext;
    logic [AW-1:0]         w_wr_addr;
    logic [AW-1:0]         w_rd_addr;
    logic [CNTW-1:0]       w_cnt;
    logic [CNTW-1:0]       w_n;
    logic signed [DIFF_W-1:0] w_dx;
    logic signed [DIFF_W-1:0] w_dy;
    logic signed [DIFF_W-1:0] w_dz;
    logic signed [SQ_W-1:0]   w_dxe;
    logic signed [SQ_W-1:0]   w_dye;
    logic signed [SQ_W-1:0]   w_dze;

    // Decode addresses and the scan length
    assign w_slot_ext = {{AW{1'b0}}, i_q_data.atom_index};
    assign w_wr_addr  = w_slot_ext[AW-1:0];
    assign w_rd_addr  = r_idx[AW-1:0];
    assign w_cnt      = CNTW'(i_atom_count);
    assign w_n        = (w_cnt > N_MAX) ? N_MAX : w_cnt;

    assign w_rd_en     = (r_state == S_SCAN) && (r_idx != r_n);
    assign w_scan_done = (r_idx == r_n) && !r_v1 && !r_v2 && !r_v3;

    // Sequence commands from the queue
    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        w_wr_en     = 1'b0;
        w_start     = 1'b0;
        o_req_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_data.command == CMD_QUERY) begin
                        w_start = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        w_wr_en = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (w_scan_done) begin
                    n_state = S_HAND;
                end
            end
            S_HAND: begin
                o_req_valid = 1'b1;
                if (i_req_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req = '{dist_sq: r_best, is_bulk: r_bulk};

    // Point store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= '{x: i_q_data.point_x, y: i_q_data.point_y,
                                  z: i_q_data.point_z};
        end
        if (w_rd_en) begin
            r_mem_q <= r_mem[w_rd_addr];
        end
    end

    // Coordinate differences and squares
    assign w_dx  = DIFF_W'(r_qx) - DIFF_W'(r_mem_q.x);
    assign w_dy  = DIFF_W'(r_qy) - DIFF_W'(r_mem_q.y);
    assign w_dz  = DIFF_W'(r_qz) - DIFF_W'(r_mem_q.z);
    assign w_dxe = SQ_W'(w_dx);
    assign w_dye = SQ_W'(w_dy);
    assign w_dze = SQ_W'(w_dz);

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_qx <= i_q_data.point_x;
            r_qy <= i_q_data.point_y;
            r_qz <= i_q_data.point_z;
            r_n  <= w_n;
        end
        r_sqx <= SQ_W'(w_dxe * w_dxe);
        r_sqy <= SQ_W'(w_dye * w_dye);
        r_sqz <= SQ_W'(w_dze * w_dze);
        r_dsq <= DSQ_W'(r_sqx) + DSQ_W'(r_sqy) + DSQ_W'(r_sqz);
    end

    // Control: state, scan index, stage valids, running minimum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_best  <= CEILING_SQ;
            r_bulk  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_v1    <= w_rd_en;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            if (w_start) begin
                r_idx  <= '0;
                r_best <= CEILING_SQ;
                r_bulk <= 1'b1;
            end else begin
                if (w_rd_en) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_v3) begin
                    if (r_dsq <= DSQ_W'(i_bulk_dist_sq)) begin
                        r_bulk <= 1'b0;
                    end
                    if (r_dsq < DSQ_W'(r_best)) begin
                        r_best <= r_dsq[DIST_SQ_W-1:0];
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/vnpd_sqrt.sv
// Iterative floor square root, one root bit per cycle, with result register.
`default_nettype none

module vnpd_sqrt (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_req_valid,
    output logic                 o_req_ready,
    input  vnpd_pkg::t_sqrt_req  i_req,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output vnpd_pkg::t_out       o_out_data
);
    import vnpd_pkg::*;

    logic                  r_busy;
    logic [DIST_SQ_W-1:0]  r_op;
    logic [DIST_SQ_W-1:0]  r_res;
    logic [DIST_SQ_W-1:0]  r_one;
    t_sqrt_req             r_req;
    logic                  r_out_valid;
    t_out                  r_out;
    logic [DIST_SQ_W-1:0]  w_trial;
    logic                  w_take;
    logic                  w_iter_done;
    logic                  w_load_out;

    assign o_req_ready = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_take      = i_req_valid && !r_busy;
    assign w_trial     = r_res + r_one;
    assign w_iter_done = r_busy && (r_one == '0);
    assign w_load_out  = w_iter_done && (!r_out_valid || i_out_ready);

    // Iterate the remainder and partial root
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req <= i_req;
            r_op  <= i_req.dist_sq;
            r_res <= '0;
            r_one <= SQRT_ONE_INIT;
        end else if (r_busy && !w_iter_done) begin
            if (r_op >= w_trial) begin
                r_op  <= r_op - w_trial;
                r_res <= (r_res >> 1) + r_one;
            end else begin
                r_res <= r_res >> 1;
            end
            r_one <= r_one >> 2;
        end
        if (w_load_out) begin
            r_out <= '{min_dist_sq: r_req.dist_sq,
                       min_dist:    r_res[DIST_W-1:0],
                       is_bulk:     r_req.is_bulk};
        end
    end

    // Track busy and the output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_busy <= 1'b1;
            end else if (w_load_out) begin
                r_busy <= 1'b0;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
